[hdl/rmq_pkg.sv]
// Shared widths, types and codes of the matrix-to-quaternion pipeline.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int W = 16;              // word width
  localparam int F = 14;              // fraction bits
  localparam int ONE = 1 << F;
  localparam int D_W = W + 2;         // sums and differences of entries, trace
  localparam int RAD_W = W + 2;       // positive radicand, unsigned
  localparam int SQ_HALF = (W + F + 3) / 2;
  localparam int ROOT_W = ((SQ_HALF + 1) / 2) * 2;  // even, two root bits a stage
  localparam int SQ_W = 2 * ROOT_W;
  localparam int DIV_A = W + F + 2;
  localparam int DIV_B = ROOT_W + W + 1;
  localparam int DIV_W = (DIV_A > DIV_B) ? DIV_A : DIV_B;

  typedef logic signed [W-1:0] word_t;
  typedef logic signed [D_W-1:0] dw_t;

  // where the square-root component lands
  typedef enum logic [1:0] {
    POS_W,
    POS_X,
    POS_Y,
    POS_Z
  } pos_t;

  typedef struct packed {
    dw_t  d0;
    dw_t  d1;
    dw_t  d2;
    pos_t pos;
    logic deg;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    side_t            side;
  } front_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    side_t             side;
  } root_t;

  typedef struct packed {
    logic [2:0][W-2:0] q;
    logic [2:0]        neg;
    logic [2:0]        over;
    logic [ROOT_W-1:0] root;
    pos_t              pos;
    logic              deg;
  } quo_t;

endpackage

[hdl/rmq_mat_if.sv]
// Input channel: one rotation matrix word.
`timescale 1ns / 1ps
interface rmq_mat_if import rmq_pkg::*;;
  logic  valid;
  logic  ready;
  word_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

[hdl/rmq_quat_if.sv]
// Output channel: one quaternion word with degenerate flag.
`timescale 1ns / 1ps
interface rmq_quat_if import rmq_pkg::*;;
  logic  valid;
  logic  ready;
  word_t qw, qx, qy, qz;
  logic  degenerate;

  modport source(output valid, qw, qx, qy, qz, degenerate, input ready);
  modport sink(input valid, qw, qx, qy, qz, degenerate, output ready);
endinterface

[hdl/rmq_front.sv]
// Front end: trace, diagonal pick, radicand and off-diagonal lane terms.
`timescale 1ns / 1ps
module rmq_front import rmq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  rmq_mat_if.sink mat,
  output logic   out_valid,
  input  logic   out_ready,
  output front_t out_data
);

  typedef logic signed [RAD_W:0] rs_t;

  logic va, vb, go_a, go_b;
  dw_t   trace, a21, a02, a10, s10, s20, s21;
  word_t d00, d11, d22;
  pos_t  pick;
  logic  i1;
  word_t mx;

  front_t fb_next;
  rs_t    rad_s;
  logic   tpos;

  assign go_b = !vb || out_ready;
  assign go_a = !va || go_b;
  assign mat.ready = go_a;
  assign out_valid = vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (go_a) va <= mat.valid;
      if (go_b) vb <= va;
    end
  end

  // lower index wins ties
  assign i1 = mat.m11 > mat.m00;
  assign mx = i1 ? mat.m11 : mat.m00;

  always_ff @(posedge clk) begin
    if (go_a) begin
      trace <= D_W'(mat.m00) + D_W'(mat.m11) + D_W'(mat.m22);
      a21   <= D_W'(mat.m21) - D_W'(mat.m12);
      a02   <= D_W'(mat.m02) - D_W'(mat.m20);
      a10   <= D_W'(mat.m10) - D_W'(mat.m01);
      s10   <= D_W'(mat.m10) + D_W'(mat.m01);
      s20   <= D_W'(mat.m20) + D_W'(mat.m02);
      s21   <= D_W'(mat.m21) + D_W'(mat.m12);
      d00   <= mat.m00;
      d11   <= mat.m11;
      d22   <= mat.m22;
      pick  <= (mat.m22 > mx) ? POS_Z : (i1 ? POS_Y : POS_X);
    end
  end

  always_comb begin
    tpos = trace > 0;
    fb_next.side.pos = POS_W;
    fb_next.side.d0 = a21;
    fb_next.side.d1 = a02;
    fb_next.side.d2 = a10;
    rad_s = RAD_W'(trace) + rs_t'(ONE);
    if (!tpos) begin
      case (pick)
        POS_Y: begin
          fb_next.side.pos = POS_Y;
          rad_s = rs_t'(d11) - rs_t'(d22) - rs_t'(d00) + rs_t'(ONE);
          fb_next.side.d0 = a02;
          fb_next.side.d1 = s10;
          fb_next.side.d2 = s21;
        end
        POS_Z: begin
          fb_next.side.pos = POS_Z;
          rad_s = rs_t'(d22) - rs_t'(d00) - rs_t'(d11) + rs_t'(ONE);
          fb_next.side.d0 = a10;
          fb_next.side.d1 = s20;
          fb_next.side.d2 = s21;
        end
        default: begin
          fb_next.side.pos = POS_X;
          rad_s = rs_t'(d00) - rs_t'(d11) - rs_t'(d22) + rs_t'(ONE);
          fb_next.side.d0 = a21;
          fb_next.side.d1 = s10;
          fb_next.side.d2 = s20;
        end
      endcase
    end
    if (tpos) rad_s = rs_t'(trace) + rs_t'(ONE);
    fb_next.side.deg = !tpos && (rad_s <= 0);
    // a degenerate word still needs a nonzero divisor downstream
    fb_next.rad = fb_next.side.deg ? RAD_W'(1) : rad_s[RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (go_b) out_data <= fb_next;
  end

endmodule

[hdl/rmq_sqrt.sv]
// Pipelined integer square root of rad * 2^F, two root bits per stage.
`timescale 1ns / 1ps
module rmq_sqrt import rmq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output root_t  out_data
);

  localparam int NS = ROOT_W / 2;
  localparam int RW = ROOT_W + 3;

  typedef struct packed {
    logic [RW-1:0]     rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   n;
    side_t             side;
  } sq_st_t;

  sq_st_t        st [NS];
  sq_st_t        st_next [NS];
  logic [NS-1:0] v, go;

  always_comb begin
    go[NS-1] = !v[NS-1] || out_ready;
    for (int s = NS - 2; s >= 0; s--) go[s] = !v[s] || go[s+1];
  end
  assign in_ready = go[0];
  assign out_valid = v[NS-1];
  assign out_data.root = st[NS-1].root;
  assign out_data.side = st[NS-1].side;

  always_comb begin
    sq_st_t        cur;
    logic [RW-1:0] remx, trial;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        cur.rem = '0;
        cur.root = '0;
        cur.n = SQ_W'(in_data.rad) << F;
        cur.side = in_data.side;
      end else begin
        cur = st[s-1];
      end
      for (int t = 0; t < 2; t++) begin
        remx = {cur.rem[RW-3:0], cur.n[SQ_W-1 -: 2]};
        trial = {1'b0, cur.root, 2'b01};
        cur.n = cur.n << 2;
        if (remx >= trial) begin
          cur.rem = remx - trial;
          cur.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
          cur.rem = remx;
          cur.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
      end
      st_next[s] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (go[s]) v[s] <= (s == 0) ? in_valid : v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (go[s]) st[s] <= st_next[s];
    end
  end

endmodule

[hdl/rmq_div.sv]
// Three-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module rmq_div import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  root_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output quo_t  out_data
);

  // setup stage, then one stage per quotient bit below the overflow bit
  localparam int NS = W;

  typedef struct packed {
    logic [2:0][DIV_W-1:0] rem;
    logic [ROOT_W:0]       den;
    quo_t                  qo;
  } dv_st_t;

  dv_st_t        st [NS];
  dv_st_t        st_next [NS];
  logic [NS-1:0] v, go;

  always_comb begin
    go[NS-1] = !v[NS-1] || out_ready;
    for (int s = NS - 2; s >= 0; s--) go[s] = !v[s] || go[s+1];
  end
  assign in_ready = go[0];
  assign out_valid = v[NS-1];
  assign out_data = st[NS-1].qo;

  always_comb begin
    dv_st_t           cur;
    dw_t              d [3];
    dw_t              mag;
    logic [DIV_W-1:0] sh;
    d[0] = in_data.side.d0;
    d[1] = in_data.side.d1;
    d[2] = in_data.side.d2;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        cur.den = {in_data.root, 1'b0};
        cur.qo.root = in_data.root;
        cur.qo.pos = in_data.side.pos;
        cur.qo.deg = in_data.side.deg;
        cur.qo.q = '0;
        // numerator |d| * 2^F plus half the divisor rounds to nearest
        sh = DIV_W'(cur.den) << (W - 1);
        for (int l = 0; l < 3; l++) begin
          cur.qo.neg[l] = d[l] < 0;
          mag = cur.qo.neg[l] ? -d[l] : d[l];
          cur.rem[l] = (DIV_W'(mag) << F) + DIV_W'(in_data.root);
          cur.qo.over[l] = cur.rem[l] >= sh;
        end
      end else begin
        cur = st[s-1];
        sh = DIV_W'(cur.den) << (W - 1 - s);
        for (int l = 0; l < 3; l++) begin
          if (cur.rem[l] >= sh) begin
            cur.rem[l] = cur.rem[l] - sh;
            cur.qo.q[l][W-1-s] = 1'b1;
          end
        end
      end
      st_next[s] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (go[s]) v[s] <= (s == 0) ? in_valid : v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (go[s]) st[s] <= st_next[s];
    end
  end

endmodule

[hdl/rotation_matrix_to_quaternion_unit.sv]
// Rotation matrix to unit quaternion (Shepperd's method), Q2.14 words.
//
// mat (sink): nine signed matrix entries m00..m22, 1.0 = 16384.
// quat (source): qw, qx, qy, qz saturated in the same format, plus
// degenerate, set when the square-root radicand is not positive (all
// components zero then). Both channels move a word on valid && ready.
//
// Pipeline: 27 register stages, two front stages (trace, radicand),
// eight square-root stages (two root bits each), sixteen divider
// stages (setup plus one quotient bit each) and the output register.
// Throughput: one word per cycle while the receiver is ready; items
// are independent.
//
// Every stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles collapse and the block keeps accepting while
// a result waits in the output register. A stalled receiver fills the
// pipeline and then drops mat.ready; nothing is lost or repeated.
// Synchronous reset clears all valid bits; no result is pending after it.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rmq_mat_if.sink    mat,
  rmq_quat_if.source quat
);

  localparam int CW = ROOT_W + W;
  localparam word_t MAXW = word_t'((1 << (W - 1)) - 1);
  localparam word_t MINW = word_t'(-(1 << (W - 1)));

  logic   f_valid, f_ready, r_valid, r_ready, d_valid, d_ready;
  front_t f_data;
  root_t  r_data;
  quo_t   d_data;

  logic  ov, go_o;
  word_t oqw, oqx, oqy, oqz;
  logic  odeg;

  word_t             lane [3];
  word_t             big;
  logic [ROOT_W-2:0] half;

  rmq_front u_front (
    .clk, .rst, .mat,
    .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
  );

  rmq_sqrt u_sqrt (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(r_valid), .out_ready(r_ready), .out_data(r_data)
  );

  rmq_div u_div (
    .clk, .rst,
    .in_valid(r_valid), .in_ready(r_ready), .in_data(r_data),
    .out_valid(d_valid), .out_ready(d_ready), .out_data(d_data)
  );

  assign go_o = !ov || quat.ready;
  assign d_ready = go_o;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (d_data.over[l]) lane[l] = d_data.neg[l] ? MINW : MAXW;
      else if (d_data.neg[l]) lane[l] = -word_t'({1'b0, d_data.q[l]});
      else lane[l] = word_t'({1'b0, d_data.q[l]});
    end
    // sqrt(rad)/2 is the root of rad * 2^F shifted down by one
    half = d_data.root[ROOT_W-1:1];
    big = (CW'(half) > CW'(MAXW)) ? MAXW : word_t'(half);
  end

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (go_o) ov <= d_valid;
  end

  always_ff @(posedge clk) begin
    if (go_o) begin
      odeg <= d_data.deg;
      if (d_data.deg) begin
        oqw <= '0;
        oqx <= '0;
        oqy <= '0;
        oqz <= '0;
      end else begin
        oqw <= (d_data.pos == POS_W) ? big : lane[0];
        oqx <= (d_data.pos == POS_X) ? big : ((d_data.pos == POS_W) ? lane[0] : lane[1]);
        oqy <= (d_data.pos == POS_Y) ? big : ((d_data.pos == POS_Z) ? lane[2] : lane[1]);
        oqz <= (d_data.pos == POS_Z) ? big : lane[2];
      end
    end
  end

  assign quat.valid = ov;
  assign quat.qw = oqw;
  assign quat.qx = oqx;
  assign quat.qy = oqy;
  assign quat.qz = oqz;
  assign quat.degenerate = odeg;

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !quat.valid)
    else $error("output valid right after reset");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    quat.ready |-> mat.ready)
    else $error("input stalled while receiver is ready");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.degenerate |->
      quat.qw == 0 && quat.qx == 0 && quat.qy == 0 && quat.qz == 0)
    else $error("degenerate word with nonzero components");

endmodule
